>>> src/art_pkg.sv
package art_pkg;

    typedef enum logic [3:0] {
        FUNC_CLEAR    = 4'd0,
        FUNC_ADD_EP   = 4'd1,
        FUNC_ADD_CL   = 4'd2,
        FUNC_ADD_AT   = 4'd3,
        FUNC_GET      = 4'd4,
        FUNC_SET      = 4'd5,
        FUNC_DEVTYPE  = 4'd6,
        FUNC_RD_EP    = 4'd7,
        FUNC_RD_CL    = 4'd8,
        FUNC_RD_AT    = 4'd9
    } func_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EP_RD,
        S_EP_CMP,
        S_CL_RD,
        S_CL_CMP,
        S_AT_RD,
        S_AT_CMP,
        S_AT_WR,
        S_IDX_RD,
        S_IDX_WAIT,
        S_OUT
    } state_t;

endpackage

>>> src/art_ram.sv
module art_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/attribute_registry_table.sv
// Channel   Direction  Ports
// s_        in         s_valid, s_ready, s_func .. s_entry_index
// m_        out        m_valid, m_ready, m_status .. m_read_attr
//
// One word at a time. Lookups scan the tables one entry at a time, each table through
// its own compare unit on registered RAM reads; an attribute add scans the cluster
// table and then the attribute table.
// s_ready is high only in idle; a result holds in m_ register until taken.
// Reset clears the counts and the sequencer; table contents are not cleared.
module attribute_registry_table
    import art_pkg::*;
#(
    parameter int MAX_ENDPOINTS = 16,
    parameter int MAX_CLUSTERS  = 64,
    parameter int MAX_ATTRS     = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_func,
    input  logic [15:0] s_key_endpoint,
    input  logic [31:0] s_key_cluster,
    input  logic [31:0] s_key_attr,
    input  logic [63:0] s_data_value,
    input  logic [7:0]  s_data_type,
    input  logic [7:0]  s_data_flags,
    input  logic [7:0]  s_entry_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [7:0]  m_slot,
    output logic [8:0]  m_table_count,
    output logic [63:0] m_read_value,
    output logic [7:0]  m_read_type,
    output logic [7:0]  m_read_flags,
    output logic [15:0] m_read_endpoint,
    output logic [31:0] m_read_cluster,
    output logic [31:0] m_read_attr
);

    localparam int EAW = (MAX_ENDPOINTS > 1) ? $clog2(MAX_ENDPOINTS) : 1;
    localparam int CAW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int AAW = (MAX_ATTRS > 1) ? $clog2(MAX_ATTRS) : 1;
    localparam int ECW = $clog2(MAX_ENDPOINTS + 1);
    localparam int CCW = $clog2(MAX_CLUSTERS + 1);
    localparam int ACW = $clog2(MAX_ATTRS + 1);
    localparam int EPW = 16 + 32;
    localparam int CLW = 16 + 32;
    localparam int ATW = 16 + 32 + 32 + 8 + 8 + 64;

    state_t state_reg, state_next;
    logic [ECW-1:0] ep_used_reg, ep_used_next;
    logic [CCW-1:0] cl_used_reg, cl_used_next;
    logic [ACW-1:0] at_used_reg, at_used_next;
    logic [12:0] idx_reg, idx_next;

    logic [3:0]  func_reg;
    logic [15:0] ep_reg;
    logic [31:0] cl_reg, at_reg;
    logic [63:0] val_reg;
    logic [7:0]  typ_reg, flg_reg, eidx_reg;

    logic [1:0]  o_status_reg, o_status_next;
    logic [7:0]  o_slot_reg, o_slot_next;
    logic [8:0]  o_count_reg, o_count_next;
    logic [63:0] o_val_reg, o_val_next;
    logic [7:0]  o_typ_reg, o_typ_next, o_flg_reg, o_flg_next;
    logic [15:0] o_ep_reg, o_ep_next;
    logic [31:0] o_cl_reg, o_cl_next, o_at_reg, o_at_next;

    logic           ep_we, cl_we, at_we;
    logic [EAW-1:0] ep_waddr, ep_raddr;
    logic [CAW-1:0] cl_waddr, cl_raddr;
    logic [AAW-1:0] at_waddr, at_raddr;
    logic [EPW-1:0] ep_wdata, ep_rdata;
    logic [CLW-1:0] cl_wdata, cl_rdata;
    logic [ATW-1:0] at_wdata, at_rdata;

    art_ram #(.WIDTH(EPW), .DEPTH(MAX_ENDPOINTS)) u_ep_ram (
        .aclk(aclk), .we(ep_we), .waddr(ep_waddr), .wdata(ep_wdata),
        .raddr(ep_raddr), .rdata(ep_rdata)
    );
    art_ram #(.WIDTH(CLW), .DEPTH(MAX_CLUSTERS)) u_cl_ram (
        .aclk(aclk), .we(cl_we), .waddr(cl_waddr), .wdata(cl_wdata),
        .raddr(cl_raddr), .rdata(cl_rdata)
    );
    art_ram #(.WIDTH(ATW), .DEPTH(MAX_ATTRS)) u_at_ram (
        .aclk(aclk), .we(at_we), .waddr(at_waddr), .wdata(at_wdata),
        .raddr(at_raddr), .rdata(at_rdata)
    );

    logic ep_hit, cl_hit, at_hit;
    assign ep_hit = (ep_rdata[EPW-1 -: 16] == ep_reg);
    assign cl_hit = (cl_rdata[CLW-1 -: 16] == ep_reg) && (cl_rdata[31:0] == cl_reg);
    assign at_hit = (at_rdata[ATW-1 -: 16] == ep_reg) && (at_rdata[ATW-17 -: 32] == cl_reg)
        && (at_rdata[ATW-49 -: 32] == at_reg);

    assign ep_raddr = idx_reg[EAW-1:0];
    assign cl_raddr = idx_reg[CAW-1:0];
    assign at_raddr = idx_reg[AAW-1:0];

    logic [12:0] ep_cnt13, cl_cnt13, at_cnt13;
    assign ep_cnt13 = 13'(ep_used_reg);
    assign cl_cnt13 = 13'(cl_used_reg);
    assign at_cnt13 = 13'(at_used_reg);

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    idx_next = '0;
                    unique case (s_func)
                        FUNC_CLEAR:               state_next = S_OUT;
                        FUNC_ADD_EP, FUNC_DEVTYPE: state_next = S_EP_RD;
                        FUNC_ADD_CL, FUNC_ADD_AT: state_next = S_CL_RD;
                        FUNC_GET, FUNC_SET:       state_next = S_AT_RD;
                        FUNC_RD_EP, FUNC_RD_CL, FUNC_RD_AT: begin
                            idx_next   = 13'(s_entry_index);
                            state_next = S_IDX_RD;
                        end
                        default:                  state_next = S_OUT;
                    endcase
                end
            end
            S_EP_RD: state_next = (idx_reg < ep_cnt13) ? S_EP_CMP : S_OUT;
            S_EP_CMP: begin
                if (ep_hit) begin
                    state_next = S_OUT;
                end else begin
                    idx_next   = idx_reg + 13'd1;
                    state_next = S_EP_RD;
                end
            end
            S_CL_RD: begin
                if (idx_reg < cl_cnt13) begin
                    state_next = S_CL_CMP;
                end else if (func_reg == FUNC_ADD_AT && cl_used_reg < CCW'(MAX_CLUSTERS)) begin
                    idx_next   = '0;
                    state_next = S_AT_RD;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_CL_CMP: begin
                if (cl_hit) begin
                    idx_next   = '0;
                    state_next = (func_reg == FUNC_ADD_AT) ? S_AT_RD : S_OUT;
                end else begin
                    idx_next   = idx_reg + 13'd1;
                    state_next = S_CL_RD;
                end
            end
            S_AT_RD: state_next = (idx_reg < at_cnt13) ? S_AT_CMP : S_OUT;
            S_AT_CMP: begin
                if (at_hit) begin
                    state_next = S_OUT;
                end else begin
                    idx_next   = idx_reg + 13'd1;
                    state_next = S_AT_RD;
                end
            end
            S_IDX_RD:   state_next = S_IDX_WAIT;
            S_IDX_WAIT: state_next = S_OUT;
            S_AT_WR:    state_next = S_OUT;
            S_OUT:      state_next = m_ready ? S_IDLE : S_OUT;
            default:    state_next = S_IDLE;
        endcase
    end

    // Result and table updates are formed here; the scan leaves through S_OUT.
    logic cl_full, at_full, ep_full;
    assign ep_full = (ep_used_reg >= ECW'(MAX_ENDPOINTS));
    assign cl_full = (cl_used_reg >= CCW'(MAX_CLUSTERS));
    assign at_full = (at_used_reg >= ACW'(MAX_ATTRS));

    always_comb begin
        ep_used_next  = ep_used_reg;
        cl_used_next  = cl_used_reg;
        at_used_next  = at_used_reg;
        o_status_next = o_status_reg;
        o_slot_next   = o_slot_reg;
        o_count_next  = o_count_reg;
        o_val_next    = o_val_reg;
        o_typ_next    = o_typ_reg;
        o_flg_next    = o_flg_reg;
        o_ep_next     = o_ep_reg;
        o_cl_next     = o_cl_reg;
        o_at_next     = o_at_reg;
        ep_we = 1'b0; cl_we = 1'b0; at_we = 1'b0;
        ep_waddr = idx_reg[EAW-1:0];
        cl_waddr = cl_used_reg[CAW-1:0];
        at_waddr = idx_reg[AAW-1:0];
        ep_wdata = {ep_reg, val_reg[31:0]};
        cl_wdata = {ep_reg, cl_reg};
        at_wdata = {ep_reg, cl_reg, at_reg, typ_reg, flg_reg, val_reg};

        if (state_reg == S_IDLE && s_valid) begin
            o_status_next = ST_MISS;
            o_slot_next = '0; o_count_next = '0; o_val_next = '0;
            o_typ_next = '0; o_flg_next = '0; o_ep_next = '0;
            o_cl_next = '0; o_at_next = '0;
            if (s_func == FUNC_CLEAR) begin
                ep_used_next = '0; cl_used_next = '0; at_used_next = '0;
                o_status_next = ST_OK;
            end
        end

        unique case (state_reg)
            S_EP_RD: begin
                if (idx_reg >= ep_cnt13) begin
                    o_count_next = 9'(ep_used_reg);
                    if (func_reg == FUNC_ADD_EP) begin
                        if (ep_full) begin
                            o_status_next = ST_FULL;
                        end else begin
                            ep_we         = 1'b1;
                            ep_waddr      = ep_used_reg[EAW-1:0];
                            o_slot_next   = 8'(ep_used_reg);
                            ep_used_next  = ep_used_reg + ECW'(1);
                            o_count_next  = 9'(ep_used_reg + ECW'(1));
                            o_status_next = ST_OK;
                        end
                    end
                end
            end
            S_EP_CMP: begin
                if (ep_hit) begin
                    o_status_next = ST_OK;
                    o_count_next  = 9'(ep_used_reg);
                    if (func_reg == FUNC_ADD_EP) begin
                        ep_we       = 1'b1;
                        o_slot_next = 8'(idx_reg);
                    end else begin
                        o_val_next = 64'(ep_rdata[31:0]);
                    end
                end
            end
            S_CL_RD: begin
                if (idx_reg >= cl_cnt13) begin
                    if (cl_full) begin
                        o_status_next = ST_FULL;
                        o_count_next  = (func_reg == FUNC_ADD_AT) ? 9'(at_used_reg)
                                                                 : 9'(cl_used_reg);
                    end else begin
                        cl_we         = 1'b1;
                        cl_used_next  = cl_used_reg + CCW'(1);
                        o_status_next = ST_OK;
                        o_count_next  = 9'(cl_used_reg + CCW'(1));
                    end
                end
            end
            S_CL_CMP: begin
                if (cl_hit) begin
                    o_status_next = ST_OK;
                    o_count_next  = 9'(cl_used_reg);
                end
            end
            S_AT_RD: begin
                if (idx_reg >= at_cnt13) begin
                    o_count_next = 9'(at_used_reg);
                    if (func_reg == FUNC_ADD_AT) begin
                        if (at_full) begin
                            o_status_next = ST_FULL;
                        end else begin
                            at_we         = 1'b1;
                            at_waddr      = at_used_reg[AAW-1:0];
                            at_used_next  = at_used_reg + ACW'(1);
                            o_count_next  = 9'(at_used_reg + ACW'(1));
                            o_status_next = ST_OK;
                        end
                    end else begin
                        o_status_next = ST_MISS;
                    end
                end
            end
            S_AT_CMP: begin
                if (at_hit) begin
                    o_count_next = 9'(at_used_reg);
                    unique case (func_reg)
                        FUNC_ADD_AT: begin
                            at_we = 1'b1;
                            at_wdata = {at_rdata[ATW-1 -: 80], typ_reg, flg_reg, val_reg};
                            o_status_next = ST_OK;
                        end
                        FUNC_GET: begin
                            o_val_next    = at_rdata[63:0];
                            o_status_next = ST_OK;
                        end
                        default: begin
                            if (at_rdata[63:0] != val_reg) begin
                                at_we = 1'b1;
                                at_wdata = {at_rdata[ATW-1 -: 96], val_reg};
                                o_status_next = ST_OK;
                            end else begin
                                o_status_next = ST_MISS;
                            end
                        end
                    endcase
                end
            end
            S_IDX_WAIT: begin
                unique case (func_reg)
                    FUNC_RD_EP: begin
                        o_count_next = 9'(ep_used_reg);
                        if (idx_reg < ep_cnt13) begin
                            o_status_next = ST_OK;
                            o_ep_next     = ep_rdata[EPW-1 -: 16];
                            o_val_next    = 64'(ep_rdata[31:0]);
                        end
                    end
                    FUNC_RD_CL: begin
                        o_count_next = 9'(cl_used_reg);
                        if (idx_reg < cl_cnt13) begin
                            o_status_next = ST_OK;
                            o_ep_next     = cl_rdata[CLW-1 -: 16];
                            o_cl_next     = cl_rdata[31:0];
                        end
                    end
                    default: begin
                        o_count_next = 9'(at_used_reg);
                        if (idx_reg < at_cnt13) begin
                            o_status_next = ST_OK;
                            o_ep_next     = at_rdata[ATW-1 -: 16];
                            o_cl_next     = at_rdata[ATW-17 -: 32];
                            o_at_next     = at_rdata[ATW-49 -: 32];
                            o_typ_next    = at_rdata[79:72];
                            o_flg_next    = at_rdata[71:64];
                            o_val_next    = at_rdata[63:0];
                        end
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ep_used_reg <= '0;
            cl_used_reg <= '0;
            at_used_reg <= '0;
            idx_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            ep_used_reg <= ep_used_next;
            cl_used_reg <= cl_used_next;
            at_used_reg <= at_used_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_valid) begin
            func_reg <= s_func;
            ep_reg   <= s_key_endpoint;
            cl_reg   <= s_key_cluster;
            at_reg   <= s_key_attr;
            val_reg  <= s_data_value;
            typ_reg  <= s_data_type;
            flg_reg  <= s_data_flags;
            eidx_reg <= s_entry_index;
        end
        o_status_reg <= o_status_next;
        o_slot_reg   <= o_slot_next;
        o_count_reg  <= o_count_next;
        o_val_reg    <= o_val_next;
        o_typ_reg    <= o_typ_next;
        o_flg_reg    <= o_flg_next;
        o_ep_reg     <= o_ep_next;
        o_cl_reg     <= o_cl_next;
        o_at_reg     <= o_at_next;
    end

    assign s_ready         = (state_reg == S_IDLE);
    assign m_valid         = (state_reg == S_OUT);
    assign m_status        = o_status_reg;
    assign m_slot          = o_slot_reg;
    assign m_table_count   = o_count_reg;
    assign m_read_value    = o_val_reg;
    assign m_read_type     = o_typ_reg;
    assign m_read_flags    = o_flg_reg;
    assign m_read_endpoint = o_ep_reg;
    assign m_read_cluster  = o_cl_reg;
    assign m_read_attr     = o_at_reg;

    a_ready_valid_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("ready while a result is pending");
    a_ep_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ep_used_reg <= ECW'(MAX_ENDPOINTS)) else $error("endpoint count overflow");
    a_at_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        at_used_reg <= ACW'(MAX_ATTRS)) else $error("attribute count overflow");
    a_idx_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDX_WAIT) |-> (idx_reg == 13'(eidx_reg)))
        else $error("index lost during read");

endmodule

>>> sim/attribute_registry_table_tb.sv
`timescale 1ns / 1ps

module attribute_registry_table_tb
    import art_pkg::*;
();

    localparam int EP_DEPTH = 16;
    localparam int CL_DEPTH = 64;
    localparam int AT_DEPTH = 256;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  slot;
        logic [8:0]  table_count;
        logic [63:0] read_value;
        logic [7:0]  read_type;
        logic [7:0]  read_flags;
        logic [15:0] read_endpoint;
        logic [31:0] read_cluster;
        logic [31:0] read_attr;
    } reply_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [3:0]  s_func = '0;
    logic [15:0] s_key_endpoint = '0;
    logic [31:0] s_key_cluster = '0;
    logic [31:0] s_key_attr = '0;
    logic [63:0] s_data_value = '0;
    logic [7:0]  s_data_type = '0;
    logic [7:0]  s_data_flags = '0;
    logic [7:0]  s_entry_index = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [7:0]  m_slot;
    logic [8:0]  m_table_count;
    logic [63:0] m_read_value;
    logic [7:0]  m_read_type;
    logic [7:0]  m_read_flags;
    logic [15:0] m_read_endpoint;
    logic [31:0] m_read_cluster;
    logic [31:0] m_read_attr;

    attribute_registry_table dut (.*);

    always #10 aclk = ~aclk;

    logic [15:0] ep_key [EP_DEPTH];
    logic [31:0] ep_dev [EP_DEPTH];
    int          ep_cnt;
    logic [15:0] cl_ep [CL_DEPTH];
    logic [31:0] cl_id [CL_DEPTH];
    int          cl_cnt;
    logic [15:0] at_ep [AT_DEPTH];
    logic [31:0] at_cl [AT_DEPTH];
    logic [31:0] at_id [AT_DEPTH];
    logic [7:0]  at_ty [AT_DEPTH];
    logic [7:0]  at_fl [AT_DEPTH];
    logic [63:0] at_val [AT_DEPTH];
    int          at_cnt;

    reply_t pending_replies [$];
    int     mismatches = 0;
    int     words_sent = 0;
    int     words_seen = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     idle_cycles = 0;

    function automatic int attr_slot(logic [15:0] ep, logic [31:0] cl, logic [31:0] at);
        for (int i = 0; i < at_cnt; i++)
            if (at_ep[i] == ep && at_cl[i] == cl && at_id[i] == at) return i;
        return -1;
    endfunction

    function automatic logic [1:0] cluster_ensure(logic [15:0] ep, logic [31:0] cl);
        for (int i = 0; i < cl_cnt; i++)
            if (cl_ep[i] == ep && cl_id[i] == cl) return ST_OK;
        if (cl_cnt >= CL_DEPTH) return ST_FULL;
        cl_ep[cl_cnt] = ep;
        cl_id[cl_cnt] = cl;
        cl_cnt++;
        return ST_OK;
    endfunction

    function automatic reply_t registry_apply(logic [3:0] fn, logic [15:0] ep,
            logic [31:0] cl, logic [31:0] at, logic [63:0] val, logic [7:0] ty,
            logic [7:0] fl, logic [7:0] idx);
        reply_t r;
        int k;
        r = '0;
        r.status = ST_MISS;
        case (fn)
            FUNC_CLEAR: begin
                ep_cnt = 0;
                cl_cnt = 0;
                at_cnt = 0;
                r.status = ST_OK;
            end
            FUNC_ADD_EP: begin
                r.status = ST_FULL;
                for (int i = 0; i < ep_cnt; i++) begin
                    if (ep_key[i] == ep) begin
                        ep_dev[i] = val[31:0];
                        r.status = ST_OK;
                        r.slot = 8'(i);
                        break;
                    end
                end
                if (r.status != ST_OK && ep_cnt < EP_DEPTH) begin
                    ep_key[ep_cnt] = ep;
                    ep_dev[ep_cnt] = val[31:0];
                    r.slot = 8'(ep_cnt);
                    ep_cnt++;
                    r.status = ST_OK;
                end
                r.table_count = 9'(ep_cnt);
            end
            FUNC_ADD_CL: begin
                r.status = cluster_ensure(ep, cl);
                r.table_count = 9'(cl_cnt);
            end
            FUNC_ADD_AT: begin
                r.status = cluster_ensure(ep, cl);
                if (r.status == ST_OK) begin
                    k = attr_slot(ep, cl, at);
                    if (k < 0 && at_cnt >= AT_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        if (k < 0) begin
                            k = at_cnt;
                            at_ep[k] = ep;
                            at_cl[k] = cl;
                            at_id[k] = at;
                            at_cnt++;
                        end
                        at_ty[k] = ty;
                        at_fl[k] = fl;
                        at_val[k] = val;
                    end
                end
                r.table_count = 9'(at_cnt);
            end
            FUNC_GET: begin
                k = attr_slot(ep, cl, at);
                if (k >= 0) begin
                    r.status = ST_OK;
                    r.read_value = at_val[k];
                end
                r.table_count = 9'(at_cnt);
            end
            FUNC_SET: begin
                k = attr_slot(ep, cl, at);
                if (k >= 0 && at_val[k] != val) begin
                    at_val[k] = val;
                    r.status = ST_OK;
                end
                r.table_count = 9'(at_cnt);
            end
            FUNC_DEVTYPE: begin
                for (int i = 0; i < ep_cnt; i++) begin
                    if (ep_key[i] == ep) begin
                        r.status = ST_OK;
                        r.read_value = 64'(ep_dev[i]);
                        break;
                    end
                end
                r.table_count = 9'(ep_cnt);
            end
            FUNC_RD_EP: begin
                r.table_count = 9'(ep_cnt);
                if (idx < ep_cnt) begin
                    r.status = ST_OK;
                    r.read_endpoint = ep_key[idx];
                    r.read_value = 64'(ep_dev[idx]);
                end
            end
            FUNC_RD_CL: begin
                r.table_count = 9'(cl_cnt);
                if (idx < cl_cnt) begin
                    r.status = ST_OK;
                    r.read_endpoint = cl_ep[idx];
                    r.read_cluster = cl_id[idx];
                end
            end
            FUNC_RD_AT: begin
                r.table_count = 9'(at_cnt);
                if (idx < at_cnt) begin
                    r.status = ST_OK;
                    r.read_endpoint = at_ep[idx];
                    r.read_cluster = at_cl[idx];
                    r.read_attr = at_id[idx];
                    r.read_type = at_ty[idx];
                    r.read_flags = at_fl[idx];
                    r.read_value = at_val[idx];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_word(logic [3:0] fn, logic [15:0] ep, logic [31:0] cl,
            logic [31:0] at, logic [63:0] val, logic [7:0] ty, logic [7:0] fl,
            logic [7:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= fn;
        s_key_endpoint <= ep;
        s_key_cluster <= cl;
        s_key_attr <= at;
        s_data_value <= val;
        s_data_type <= ty;
        s_data_flags <= fl;
        s_entry_index <= idx;
        pending_replies.push_back(registry_apply(fn, ep, cl, at, val, ty, fl, idx));
        do @(posedge aclk); while (!(s_valid && s_ready));
        words_sent++;
    endtask

    always @(posedge aclk) begin
        if (aresetn) m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        reply_t got;
        reply_t want;
        if (aresetn && ((s_valid && s_ready) || (m_valid && m_ready))) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            got = '{m_status, m_slot, m_table_count, m_read_value, m_read_type,
                    m_read_flags, m_read_endpoint, m_read_cluster, m_read_attr};
            words_seen++;
            if (pending_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result word: %h", got);
            end else begin
                want = pending_replies.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch at result %0d:\n  expected %p\n  actual   %p",
                                 words_seen, want, got);
                end
            end
        end
    end

    function automatic logic [15:0] pick_ep();
        return ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(23));
    endfunction

    function automatic logic [31:0] pick_id();
        return ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(5));
    endfunction

    task automatic test_directed();
        send_word(FUNC_RD_EP, 0, 0, 0, 0, 0, 0, 0);
        send_word(FUNC_GET, 16'hFFFF, '1, '1, 0, 0, 0, 0);
        send_word(FUNC_ADD_EP, 16'hFFFF, 0, 0, '1, 0, 0, 0);
        send_word(FUNC_ADD_EP, 0, 0, 0, 64'h1234_5678, 0, 0, 0);
        send_word(FUNC_ADD_EP, 16'hFFFF, 0, 0, 64'hABCD, 0, 0, 0);
        send_word(FUNC_DEVTYPE, 16'hFFFF, 0, 0, 0, 0, 0, 0);
        send_word(FUNC_DEVTYPE, 7, 0, 0, 0, 0, 0, 0);
        send_word(FUNC_ADD_CL, 16'hFFFF, '1, 0, 0, 0, 0, 0);
        send_word(FUNC_ADD_CL, 16'hFFFF, '1, 0, 0, 0, 0, 0);
        send_word(FUNC_ADD_AT, 16'hFFFF, '1, '1, '1, 8'hFF, 8'hFF, 0);
        send_word(FUNC_ADD_AT, 0, 0, 0, 0, 0, 0, 0);
        send_word(FUNC_ADD_AT, 0, 0, 0, 64'h55AA, 8'h5A, 8'hA5, 0);
        send_word(FUNC_GET, 16'hFFFF, '1, '1, 0, 0, 0, 0);
        send_word(FUNC_SET, 16'hFFFF, '1, '1, '1, 0, 0, 0);
        send_word(FUNC_SET, 16'hFFFF, '1, '1, 0, 0, 0, 0);
        send_word(FUNC_SET, 3, 3, 3, 0, 0, 0, 0);
        send_word(FUNC_RD_EP, 0, 0, 0, 0, 0, 0, 1);
        send_word(FUNC_RD_CL, 0, 0, 0, 0, 0, 0, 1);
        send_word(FUNC_RD_AT, 0, 0, 0, 0, 0, 0, 0);
        send_word(FUNC_RD_AT, 0, 0, 0, 0, 0, 0, 8'hFF);
        send_word(4'd10, '1, '1, '1, '1, '1, '1, '1);
        send_word(4'd15, 0, 0, 0, 0, 0, 0, 0);
        send_word(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        send_word(FUNC_RD_CL, 0, 0, 0, 0, 0, 0, 0);
    endtask

    task automatic test_fill_tables();
        for (int i = 0; i < 18; i++)
            send_word(FUNC_ADD_EP, 16'(i + 100), 0, 0, 64'($urandom), 0, 0, 0);
        for (int i = 0; i < 66; i++)
            send_word(FUNC_ADD_CL, 1, 32'(i), 0, 0, 0, 0, 0);
        send_word(FUNC_ADD_AT, 2, 9, 0, 0, 0, 0, 0);
        for (int i = 0; i < 258; i++)
            send_word(FUNC_ADD_AT, 1, 32'(i % 64), 32'(i), {$urandom, $urandom},
                      8'($urandom), 8'($urandom), 0);
        send_word(FUNC_RD_EP, 0, 0, 0, 0, 0, 0, 15);
        send_word(FUNC_RD_CL, 0, 0, 0, 0, 0, 0, 63);
        send_word(FUNC_RD_AT, 0, 0, 0, 0, 0, 0, 255);
        send_word(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    endtask

    task automatic test_random(int count);
        logic [3:0] fn;
        logic [7:0] idx;
        for (int n = 0; n < count; n++) begin
            fn = ($urandom_range(49) == 0) ? FUNC_CLEAR : 4'($urandom_range(1, 9));
            if ($urandom_range(29) == 0) fn = 4'($urandom_range(10, 15));
            idx = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(20));
            send_word(fn, pick_ep(), pick_id(), pick_id(),
                      ($urandom_range(1)) ? {$urandom, $urandom} : 64'($urandom_range(3)),
                      8'($urandom), 8'($urandom), idx);
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_idle_pct = 37;
        recv_idle_pct = 64;
        test_directed();
        test_random(130);
        send_idle_pct = 64;
        recv_idle_pct = 37;
        test_fill_tables();
        test_random(130);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(130);
        s_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (700) @(posedge aclk);
        $display("Sent %0d words and checked %0d results across all operations,", words_sent,
                 words_seen);
        $display("including full tables, upserts, misses and out-of-range slot reads.");
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("Mismatches: %0d", mismatches);
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> sim.f
src/art_pkg.sv
src/art_ram.sv
src/attribute_registry_table.sv
sim/attribute_registry_table_tb.sv
